>>> rtl/core/gpg_pkg.sv
// Shared types for the GF(2) polynomial gcd core.
`timescale 1ns / 1ps
`default_nettype none

package gpg_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift_a;
    logic shift_b;
    logic xor_a;
    logic xor_b;
    logic capture;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_top;
    logic b_top;
    logic a_ge_b;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/gpg_if.sv
// Valid/ready channel interfaces for operands and results.
`timescale 1ns / 1ps
`default_nettype none

interface gpg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] poly_a;
  logic [31:0] poly_b;

  modport source (output valid, output poly_a, output poly_b, input ready);
  modport sink (input valid, input poly_a, input poly_b, output ready);
endinterface

interface gpg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] gcd_poly;

  modport source (output valid, output gcd_poly, input ready);
  modport sink (input valid, input gcd_poly, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gf2_polynomial_gcd_core.sv
// Top level of the GF(2) polynomial gcd core.
`timescale 1ns / 1ps
`default_nettype none

// Computes the gcd of two polynomials over GF(2) (bit i is the coefficient
// of x^i); inputs are masked to WIDTH bits and the result is zero-extended
// or truncated to 32 bits. gcd(a,0)=a, gcd(0,b)=b, gcd(0,0)=0. One operand
// pair is worked on at a time: after the transfer in, the datapath performs
// one step per cycle, either a one-bit alignment shift of an operand or an
// XOR reduction of the higher-degree operand by the other, until one operand
// is zero. The result sits in an output register, so a new pair can be
// transferred in while it waits.
module gf2_polynomial_gcd_core #(
  parameter int WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  gpg_in_if.sink    operands,
  gpg_out_if.source result
);

  gpg_pkg::cmd_t    cmd;
  gpg_pkg::status_t status;

  gpg_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gpg_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .poly_a   (operands.poly_a),
    .poly_b   (operands.poly_b),
    .status   (status),
    .gcd_poly (result.gcd_poly)
  );

endmodule

`default_nettype wire

>>> rtl/core/gpg_datapath.sv
// Datapath: left-aligned operand registers, degree counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module gpg_datapath #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire gpg_pkg::cmd_t    cmd,
  input  wire logic [31:0]      poly_a,
  input  wire logic [31:0]      poly_b,
  output gpg_pkg::status_t      status,
  output logic [31:0]           gcd_poly
);

  localparam int DW = $clog2(WIDTH);
  localparam int EW = (WIDTH > 32) ? WIDTH : 32;
  localparam logic [DW-1:0] TOP = DW'(WIDTH - 1);

  // Operands are shifted up until their leading coefficient is at the top bit; the
  // degree counters remember how far each one has been shifted up.
  logic [WIDTH-1:0] a, b;
  logic [DW-1:0]    da, db;
  logic [WIDTH-1:0] res;
  logic [EW-1:0]    a_ext, b_ext, res_ext;
  logic [WIDTH-1:0] res_next;

  assign a_ext = EW'(poly_a);
  assign b_ext = EW'(poly_b);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a  <= a_ext[WIDTH-1:0];
      b  <= b_ext[WIDTH-1:0];
      da <= TOP;
      db <= TOP;
    end else begin
      if (cmd.shift_a) begin
        a  <= {a[WIDTH-2:0], 1'b0};
        da <= da - 1'b1;
      end
      if (cmd.shift_b) begin
        b  <= {b[WIDTH-2:0], 1'b0};
        db <= db - 1'b1;
      end
      if (cmd.xor_a) begin
        a <= a ^ b;
      end
      if (cmd.xor_b) begin
        b <= b ^ a;
      end
    end
    if (cmd.capture) begin
      res <= res_next;
    end
  end

  // When one operand has reached zero the other, moved back down, is the gcd.
  always_comb begin
    if (status.a_zero) begin
      res_next = b >> (TOP - db);
    end else begin
      res_next = a >> (TOP - da);
    end
  end

  assign status.a_zero = (a == '0);
  assign status.b_zero = (b == '0);
  assign status.a_top  = a[WIDTH-1];
  assign status.b_top  = b[WIDTH-1];
  assign status.a_ge_b = (da >= db);

  assign res_ext  = EW'(res);
  assign gcd_poly = res_ext[31:0];

`ifndef SYNTH
  // An XOR step must clear the leading coefficient of the reduced operand.
  a_xor_clears_top : assert property (@(posedge clk)
    cmd.xor_a && !cmd.load |=> !a[WIDTH-1])
    else $error("xor step left top bit of a set");
  b_xor_clears_top : assert property (@(posedge clk)
    cmd.xor_b && !cmd.load |=> !b[WIDTH-1])
    else $error("xor step left top bit of b set");
  // Reduction only happens between two aligned operands.
  xor_needs_aligned : assert property (@(posedge clk)
    (cmd.xor_a || cmd.xor_b) |-> (a[WIDTH-1] && b[WIDTH-1]))
    else $error("xor step on unaligned operands");
`endif

endmodule

`default_nettype wire

>>> rtl/core/gpg_controller.sv
// Controller: sequences normalize and reduce steps and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module gpg_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire gpg_pkg::status_t  status,
  output gpg_pkg::cmd_t          cmd
);

  gpg_pkg::state_t state, state_next;
  logic            finish;

  // The run ends once either operand is zero and the output register is free.
  assign finish = (status.a_zero || status.b_zero) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gpg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gpg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = gpg_pkg::ST_RUN;
        end
      end
      gpg_pkg::ST_RUN: begin
        if (finish) begin
          state_next = gpg_pkg::ST_IDLE;
        end
      end
      default: state_next = gpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      gpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      gpg_pkg::ST_RUN: begin
        if (status.a_zero || status.b_zero) begin
          cmd.capture = finish;
        end else if (!status.a_top) begin
          cmd.shift_a = 1'b1;
        end else if (!status.b_top) begin
          cmd.shift_b = 1'b1;
        end else if (status.a_ge_b) begin
          cmd.xor_a = 1'b1;
        end else begin
          cmd.xor_b = 1'b1;
        end
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  capture_sets_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> out_valid)
    else $error("captured result not presented");
  no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");
  accept_starts_run : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == gpg_pkg::ST_RUN)
    else $error("accepted operands did not start a run");
`endif

endmodule

`default_nettype wire
